FILE: hdl/md5sh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hasher package
// Shared constants, control types and round tables of the MD5 compression.
// ----------------------------------------------------------------------------
package md5sh_pkg;

	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned BLK_AW    = $clog2(BLK_WORDS);
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned CNT_W     = 61;

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0]  PAD_BYTE   = 8'h80;
	localparam logic [5:0]  LAST_ROUND = 6'd63;

	typedef struct packed {
		logic start;
		logic init;
	} md5sh_ctl_t;

	function automatic logic [31:0] md5sh_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5sh_s(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// Message word index used by round r
	function automatic logic [BLK_AW-1:0] md5sh_g(input logic [5:0] r);
		logic [BLK_AW-1:0] lo;
		logic [BLK_AW-1:0] g;
		lo = r[BLK_AW-1:0];
		case (r[5:4])
			2'd0:    g = lo;
			2'd1:    g = BLK_AW'(5 * lo + 1);
			2'd2:    g = BLK_AW'(3 * lo + 5);
			default: g = BLK_AW'(7 * lo);
		endcase
		return g;
	endfunction

endpackage

FILE: hdl/md5sh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hasher generic RAM
// Simple dual-port memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module md5sh_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/md5sh_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hasher compression core
// One MD5 round per cycle over the block memory; holds the chaining words.
// ----------------------------------------------------------------------------
module md5sh_core import md5sh_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  md5sh_ctl_t             ctl,
	output logic [BLK_AW-1:0]      raddr,
	input  logic [WORD_W-1:0]      rdata,
	output logic                   done,
	output logic [3:0][WORD_W-1:0] chain
);

	logic [3:0][WORD_W-1:0] chain_q;
	logic [WORD_W-1:0]      a_q, b_q, c_q, d_q;
	logic [5:0]             rc_q;
	logic                   busy_q;
	logic                   v_s1;
	logic [5:0]             r_s1;
	logic                   fin_s2;

	logic [WORD_W-1:0]      f;
	logic [WORD_W-1:0]      sum;
	logic [2*WORD_W-1:0]    rot2;
	logic [WORD_W-1:0]      b_nxt;

	assign raddr = md5sh_g(rc_q);
	assign done  = fin_s2;
	assign chain = chain_q;

	always_comb begin
		case (r_s1[5:4])
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (d_q & b_q) | (~d_q & c_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum   = a_q + f + md5sh_k(r_s1) + rdata;
		rot2  = {sum, sum} << md5sh_s(r_s1);
		b_nxt = b_q + rot2[2*WORD_W-1:WORD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= {IV_D, IV_C, IV_B, IV_A};
			busy_q  <= 1'b0;
			rc_q    <= '0;
			v_s1    <= 1'b0;
			r_s1    <= '0;
			fin_s2  <= 1'b0;
		end else begin
			v_s1   <= busy_q;
			r_s1   <= rc_q;
			fin_s2 <= v_s1 && (r_s1 == LAST_ROUND);
			if (ctl.start) begin
				busy_q <= 1'b1;
				rc_q   <= '0;
			end else if (busy_q) begin
				rc_q <= rc_q + 6'd1;
				if (rc_q == LAST_ROUND) begin
					busy_q <= 1'b0;
				end
			end
			if (ctl.init) begin
				chain_q <= {IV_D, IV_C, IV_B, IV_A};
			end else if (fin_s2) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (v_s1) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_nxt;
		end
	end

endmodule

FILE: hdl/md5_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hasher
// Absorbs message bytes into a 16-word block memory, pads on finish and
// emits the four digest words.
// A data byte is accepted while the hasher is idle; the 64th byte of a block
// starts a compression that holds the input stalled (one round per cycle,
// block memory read registered ahead of each round).
// Finish: up to 16 padding writes and a start, then a compression, twice
// when 56 or more bytes are held, then four digest words.
// Reset loads the MD5 initial chaining words and clears all counts; the
// block memory is not cleared.
// ----------------------------------------------------------------------------
module md5_stream_hasher import md5sh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] digest_word,
	output logic [1:0]        word_index,
	output logic              last
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD  = 4'b0010,
		ST_HASH = 4'b0100,
		ST_EMIT = 4'b1000
	} st_t;

	st_t                    state_q;
	logic [5:0]             fill_q;
	logic [CNT_W-1:0]       count_q;
	logic [WORD_W-1:0]      acc_q;
	logic [BLK_AW:0]        wp_q;
	logic                   len_q;
	logic                   fin_q;
	logic [1:0]             oi_q;

	md5sh_ctl_t             ctl;
	logic                   done;
	logic [3:0][WORD_W-1:0] chain;
	logic [BLK_AW-1:0]      raddr;
	logic [WORD_W-1:0]      rdata;
	logic                   we;
	logic [BLK_AW-1:0]      waddr;
	logic [WORD_W-1:0]      wdata;

	logic                   in_acc;
	logic                   out_acc;
	logic [WORD_W-1:0]      acc_nxt;
	logic [WORD_W-1:0]      pad_word;
	logic [63:0]            bit_len;
	logic [BLK_AW-1:0]      idx;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = (state_q == ST_EMIT);
	assign out_acc     = out_valid && !out_stall;
	assign digest_word = chain[oi_q];
	assign word_index  = oi_q;
	assign last        = (oi_q == 2'd3);
	assign bit_len     = {count_q, 3'b000};
	assign idx         = fill_q[5:2];

	always_comb begin
		acc_nxt = acc_q;
		acc_nxt[8*fill_q[1:0] +: 8] = data_byte;
		for (int i = 0; i < 4; i++) begin
			if (2'(i) < fill_q[1:0]) begin
				pad_word[8*i +: 8] = acc_q[8*i +: 8];
			end else if (2'(i) == fill_q[1:0]) begin
				pad_word[8*i +: 8] = PAD_BYTE;
			end else begin
				pad_word[8*i +: 8] = 8'h00;
			end
		end
	end

	always_comb begin
		we        = 1'b0;
		waddr     = idx;
		wdata     = acc_nxt;
		ctl.start = 1'b0;
		ctl.init  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && mode == MODE_ABSORB) begin
					we        = (fill_q[1:0] == 2'd3);
					ctl.start = (fill_q == 6'd63);
				end else if (in_acc) begin
					we    = 1'b1;
					wdata = pad_word;
				end
			end
			ST_PAD: begin
				waddr = wp_q[BLK_AW-1:0];
				if (wp_q[BLK_AW]) begin
					ctl.start = 1'b1;
				end else begin
					we = 1'b1;
					if (len_q && wp_q[BLK_AW-1:0] == BLK_AW'(BLK_WORDS - 2)) begin
						wdata = bit_len[31:0];
					end else if (len_q && wp_q[BLK_AW-1:0] == BLK_AW'(BLK_WORDS - 1)) begin
						wdata = bit_len[63:32];
					end else begin
						wdata = '0;
					end
				end
			end
			ST_HASH: begin
			end
			ST_EMIT: begin
				ctl.init = out_acc && (oi_q == 2'd3);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			count_q <= '0;
			wp_q    <= '0;
			len_q   <= 1'b0;
			fin_q   <= 1'b0;
			oi_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && mode == MODE_ABSORB) begin
						fill_q  <= fill_q + 6'd1;
						count_q <= count_q + CNT_W'(1);
						if (fill_q == 6'd63) begin
							fin_q   <= 1'b0;
							state_q <= ST_HASH;
						end
					end else if (in_acc) begin
						wp_q    <= {1'b0, idx} + (BLK_AW+1)'(1);
						len_q   <= (idx < BLK_AW'(BLK_WORDS - 2));
						fin_q   <= 1'b1;
						state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					wp_q <= wp_q + (BLK_AW+1)'(1);
					if (wp_q[BLK_AW]) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (done) begin
						if (!fin_q) begin
							state_q <= ST_IDLE;
						end else if (!len_q) begin
							wp_q    <= '0;
							len_q   <= 1'b1;
							state_q <= ST_PAD;
						end else begin
							oi_q    <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						oi_q <= oi_q + 2'd1;
						if (oi_q == 2'd3) begin
							fill_q  <= '0;
							count_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Gather bytes of the current word
	always_ff @(posedge clk) begin
		if (in_acc && mode == MODE_ABSORB) begin
			acc_q <= acc_nxt;
		end
	end

	md5sh_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BLK_WORDS)
	) u_blk_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	md5sh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.raddr  (raddr),
		.rdata  (rdata),
		.done   (done),
		.chain  (chain)
	);

endmodule
